// File: src/s3e_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_pkg
// Shared constants and types for the symmetric 3x3 eigenvector block.
// ----------------------------------------------------------------------------
package s3e_pkg;

  localparam int unsigned DATA_WIDTH_DEF = 32;
  localparam int unsigned FRAC_BITS_DEF  = 24;
  localparam int unsigned TOL_RESET      = 17;
  localparam int unsigned FIFO_DEPTH     = 8;

  // result status codes
  typedef enum logic [1:0] {
    ST_SOLVED  = 2'd0,
    ST_ALIGNED = 2'd1,
    ST_NOSOL   = 2'd2,
    ST_NODIV   = 2'd3
  } status_e;

  // control part of one queued word
  typedef struct packed {
    logic    imm;       // result known at classification
    logic    plane;     // single-division plane case
    logic    plane_yz;  // yz plane (x = 0, z = 1), else xy plane
    logic [2:0] axis;   // one-hot unit axis for an aligned result, else zero
    status_e status;
  } job_ctrl_t;

endpackage

// File: src/s3e_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_div
// Bit-serial restoring divider: |num| * 2^s / |den|, truncated, saturated to
// the signed data range, sign applied at the end. One quotient bit a cycle.
// ----------------------------------------------------------------------------
module s3e_div #(
  parameter int unsigned DW = 32,
  parameter int unsigned F  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  logic signed [2*DW-1:0] num_i,
  input  logic signed [2*DW-1:0] den_i,
  input  logic                   shift_i,
  output logic                   done_o,
  output logic signed [DW-1:0]   quo_o
);
  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned NW   = PW + F;
  localparam int unsigned QW   = DW - 1;
  localparam int unsigned HW   = NW - QW;
  localparam int unsigned CMPW = (HW > PW) ? HW : PW;
  localparam int unsigned CNTW = $clog2(QW);

  logic [PW-1:0]   nmag, dmag;
  logic [NW-1:0]   nfull;
  logic [HW-1:0]   hi;
  logic            sat;
  logic            busy_q;
  logic [CNTW-1:0] cnt_q;
  logic [PW-1:0]   r_q, d_q;
  logic [QW-1:0]   lo_q, q_q;
  logic            neg_q;
  logic            done_q;
  logic signed [DW-1:0] quo_q;
  logic [PW:0]     r2;
  logic            ge;
  logic [PW-1:0]   r_d;
  logic [QW-1:0]   q_d;

  // split the operands
  always_comb begin
    nmag  = num_i[PW-1] ? PW'(-num_i) : PW'(num_i);
    dmag  = den_i[PW-1] ? PW'(-den_i) : PW'(den_i);
    nfull = shift_i ? {nmag, {F{1'b0}}} : NW'(nmag);
    hi    = nfull[NW-1:QW];
    sat   = CMPW'(hi) >= CMPW'(dmag);
  end

  // one restoring step
  always_comb begin
    r2  = {r_q, lo_q[QW-1]};
    ge  = r2 >= {1'b0, d_q};
    r_d = ge ? PW'(r2 - {1'b0, d_q}) : PW'(r2);
    q_d = {q_q[QW-2:0], ge};
  end

  // sequence the division
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        neg_q <= num_i[PW-1] ^ den_i[PW-1];
        d_q   <= dmag;
        r_q   <= PW'(hi);
        lo_q  <= nfull[QW-1:0];
        q_q   <= '0;
        cnt_q <= '0;
        if (dmag == '0) begin
          quo_q  <= '0;
          done_q <= 1'b1;
        end else if (sat) begin
          quo_q  <= (num_i[PW-1] ^ den_i[PW-1]) ? -$signed({1'b0, {QW{1'b1}}})
                                                : $signed({1'b0, {QW{1'b1}}});
          done_q <= 1'b1;
        end else begin
          busy_q <= 1'b1;
        end
      end else if (busy_q) begin
        r_q   <= r_d;
        q_q   <= q_d;
        lo_q  <= {lo_q[QW-2:0], 1'b0};
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == CNTW'(QW - 1)) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
          quo_q  <= neg_q ? -$signed({1'b0, q_d}) : $signed({1'b0, q_d});
        end
      end
    end
  end

  assign done_o = done_q;
  assign quo_o  = quo_q;

endmodule

// File: src/s3e_fifo.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_fifo
// Short word queue between the classifying front and the solving back.
// ----------------------------------------------------------------------------
module s3e_fifo #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       push_i,
  input  logic [WIDTH-1:0]           wdata_i,
  input  logic                       pop_i,
  output logic [WIDTH-1:0]           rdata_o,
  output logic                       empty_o,
  output logic [$clog2(DEPTH+1)-1:0] count_o
);
  localparam int unsigned AW = $clog2(DEPTH);

  logic [WIDTH-1:0]           mem_q [DEPTH];
  logic [AW-1:0]              wptr_q, rptr_q;
  logic [$clog2(DEPTH+1)-1:0] cnt_q;

  // store incoming words
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wptr_q] <= wdata_i;
    end
  end

  // advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      cnt_q  <= '0;
    end else begin
      if (push_i) wptr_q <= wptr_q + 1'b1;
      if (pop_i)  rptr_q <= rptr_q + 1'b1;
      if (push_i && !pop_i)      cnt_q <= cnt_q + 1'b1;
      else if (pop_i && !push_i) cnt_q <= cnt_q - 1'b1;
    end
  end

  assign rdata_o = mem_q[rptr_q];
  assign empty_o = (cnt_q == '0);
  assign count_o = cnt_q;

endmodule

// File: src/s3e_front.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_front
// Two-stage front: shift the diagonal, form the products, test against the
// tolerance and pick the case; emit one queue word per accepted item.
// ----------------------------------------------------------------------------
module s3e_front #(
  parameter int unsigned DW = 32,
  parameter int unsigned F  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   valid_i,
  input  logic signed [DW-1:0]   a_xx_i,
  input  logic signed [DW-1:0]   a_xy_i,
  input  logic signed [DW-1:0]   a_xz_i,
  input  logic signed [DW-1:0]   a_yy_i,
  input  logic signed [DW-1:0]   a_yz_i,
  input  logic signed [DW-1:0]   a_zz_i,
  input  logic signed [DW-1:0]   lambda_i,
  input  logic [F:0]             tol_i,
  output logic                   valid_o,
  output s3e_pkg::job_ctrl_t     ctrl_o,
  output logic signed [2*DW-1:0] num_a_o,
  output logic signed [2*DW-1:0] den_a_o,
  output logic signed [DW-1:0]   mul_m_o,
  output logic signed [2*DW-1:0] add_c_o,
  output logic signed [2*DW-1:0] den_b_o,
  output logic [1:0]             inflight_o
);
  import s3e_pkg::*;

  localparam int unsigned PW = 2 * DW;
  localparam int unsigned TW = F + 1;
  localparam int unsigned CW = (DW > TW) ? DW : TW;

  function automatic logic signed [DW-1:0] sat_dw(input logic signed [DW:0] v);
    if (v[DW] != v[DW-1]) begin
      sat_dw = v[DW] ? {1'b1, {(DW-1){1'b0}}} : {1'b0, {(DW-1){1'b1}}};
    end else begin
      sat_dw = v[DW-1:0];
    end
  endfunction

  function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
    mag_dw = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  function automatic logic [PW-1:0] mag_pw(input logic signed [PW-1:0] v);
    mag_pw = v[PW-1] ? PW'(-v) : PW'(v);
  endfunction

  // stage 1: diagonal minus eigenvalue
  logic                 v1_q;
  logic signed [DW-1:0] e0_q, e1_q, e2_q, xy1_q, xz1_q, yz1_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    e0_q  <= sat_dw({a_xx_i[DW-1], a_xx_i} - {lambda_i[DW-1], lambda_i});
    e1_q  <= sat_dw({a_yy_i[DW-1], a_yy_i} - {lambda_i[DW-1], lambda_i});
    e2_q  <= sat_dw({a_zz_i[DW-1], a_zz_i} - {lambda_i[DW-1], lambda_i});
    xy1_q <= a_xy_i;
    xz1_q <= a_xz_i;
    yz1_q <= a_yz_i;
  end

  // stage 2: products and tolerance flags
  logic                 v2_q;
  logic signed [PW-1:0] p_xz_e1_q, p_xy_yz_q, p_xz_yz_q, p_xy_e2_q, p_yz_yz_q;
  logic signed [PW-1:0] p_e1_e2_q, p_xy_xy_q, p_e0_e1_q, p_xy_xz_q, p_yz_e0_q;
  logic signed [DW-1:0] e0_2q, e1_2q, e2_2q, xy2_q, xz2_q, yz2_q;
  logic sm_e0_q, sm_e1_q, sm_e2_q, sm_xy_q, sm_xz_q, sm_yz_q;
  logic bg_e1_q, bg_xy_q, bg_xz_q, bg_yz_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v2_q <= 1'b0;
    end else begin
      v2_q <= v1_q;
    end
  end

  always_ff @(posedge clk_i) begin
    p_xz_e1_q <= xz1_q * e1_q;
    p_xy_yz_q <= xy1_q * yz1_q;
    p_xz_yz_q <= xz1_q * yz1_q;
    p_xy_e2_q <= xy1_q * e2_q;
    p_yz_yz_q <= yz1_q * yz1_q;
    p_e1_e2_q <= e1_q * e2_q;
    p_xy_xy_q <= xy1_q * xy1_q;
    p_e0_e1_q <= e0_q * e1_q;
    p_xy_xz_q <= xy1_q * xz1_q;
    p_yz_e0_q <= yz1_q * e0_q;
    e0_2q <= e0_q;
    e1_2q <= e1_q;
    e2_2q <= e2_q;
    xy2_q <= xy1_q;
    xz2_q <= xz1_q;
    yz2_q <= yz1_q;
    sm_e0_q <= CW'(mag_dw(e0_q))  < CW'(tol_i);
    sm_e1_q <= CW'(mag_dw(e1_q))  < CW'(tol_i);
    sm_e2_q <= CW'(mag_dw(e2_q))  < CW'(tol_i);
    sm_xy_q <= CW'(mag_dw(xy1_q)) < CW'(tol_i);
    sm_xz_q <= CW'(mag_dw(xz1_q)) < CW'(tol_i);
    sm_yz_q <= CW'(mag_dw(yz1_q)) < CW'(tol_i);
    bg_e1_q <= CW'(mag_dw(e1_q))  > CW'(tol_i);
    bg_xy_q <= CW'(mag_dw(xy1_q)) > CW'(tol_i);
    bg_xz_q <= CW'(mag_dw(xz1_q)) > CW'(tol_i);
    bg_yz_q <= CW'(mag_dw(yz1_q)) > CW'(tol_i);
  end

  // stage 3: determinants and case selection
  logic signed [PW-1:0] d1, d2, d3, num1, num2;
  logic [PW-1:0]        tol2;
  logic                 d1_ok, d2_ok, d3_ok;

  always_comb begin
    d1    = p_xz_e1_q - p_xy_yz_q;
    d2    = p_xz_yz_q - p_xy_e2_q;
    d3    = p_yz_yz_q - p_e1_e2_q;
    num1  = p_xy_xy_q - p_e0_e1_q;
    num2  = p_xy_xz_q - p_yz_e0_q;
    tol2  = PW'(tol_i) << F;
    d1_ok = mag_pw(d1) > tol2;
    d2_ok = mag_pw(d2) > tol2;
    d3_ok = mag_pw(d3) > tol2;
  end

  always_comb begin
    ctrl_o          = '0;
    ctrl_o.status   = ST_SOLVED;
    num_a_o         = num1;
    den_a_o         = d1;
    mul_m_o         = yz2_q;
    add_c_o         = PW'(0) - (PW'(xy2_q) <<< F);
    den_b_o         = PW'(e1_2q);
    priority if (sm_e0_q && sm_xy_q && sm_xz_q) begin
      ctrl_o.imm    = 1'b1;
      ctrl_o.axis   = 3'b001;
      ctrl_o.status = ST_ALIGNED;
    end else if (sm_e1_q && sm_xy_q && sm_yz_q) begin
      ctrl_o.imm    = 1'b1;
      ctrl_o.axis   = 3'b010;
      ctrl_o.status = ST_ALIGNED;
    end else if (sm_e2_q && sm_xz_q && sm_yz_q) begin
      ctrl_o.imm    = 1'b1;
      ctrl_o.axis   = 3'b100;
      ctrl_o.status = ST_ALIGNED;
    end else if (bg_xy_q && bg_xz_q) begin
      priority if (bg_e1_q && d1_ok) begin
        num_a_o = num1;
        den_a_o = d1;
      end else if (bg_yz_q && d2_ok) begin
        num_a_o = num2;
        den_a_o = d2;
        mul_m_o = e2_2q;
        add_c_o = PW'(0) - (PW'(xz2_q) <<< F);
        den_b_o = PW'(yz2_q);
      end else if (bg_yz_q && d3_ok) begin
        num_a_o = d1;
        den_a_o = d3;
        mul_m_o = e2_2q;
        add_c_o = PW'(0) - (PW'(xz2_q) <<< F);
        den_b_o = PW'(yz2_q);
      end else begin
        ctrl_o.imm    = 1'b1;
        ctrl_o.status = ST_NODIV;
      end
    end else if (bg_yz_q) begin
      ctrl_o.plane    = 1'b1;
      ctrl_o.plane_yz = 1'b1;
      num_a_o         = PW'(0) - PW'(e2_2q);
      den_a_o         = PW'(yz2_q);
    end else if (bg_xy_q) begin
      ctrl_o.plane    = 1'b1;
      num_a_o         = PW'(0) - PW'(e0_2q);
      den_a_o         = PW'(xy2_q);
    end else begin
      ctrl_o.imm    = 1'b1;
      ctrl_o.status = ST_NOSOL;
    end
  end

  assign valid_o    = v2_q;
  assign inflight_o = {1'b0, v1_q} + {1'b0, v2_q};

endmodule

// File: src/s3e_back.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_back
// Solving sequencer: divisions on a shared serial divider, the substitution
// product, sum of squares, serial square root and the normalizing divides.
// ----------------------------------------------------------------------------
module s3e_back #(
  parameter int unsigned DW = 32,
  parameter int unsigned F  = 24
) (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   job_valid_i,
  output logic                   pop_o,
  input  s3e_pkg::job_ctrl_t     ctrl_i,
  input  logic signed [2*DW-1:0] num_a_i,
  input  logic signed [2*DW-1:0] den_a_i,
  input  logic signed [DW-1:0]   mul_m_i,
  input  logic signed [2*DW-1:0] add_c_i,
  input  logic signed [2*DW-1:0] den_b_i,
  output logic                   done_o,
  output logic signed [F+1:0]    vec_x_o,
  output logic signed [F+1:0]    vec_y_o,
  output logic signed [F+1:0]    vec_z_o,
  output logic [1:0]             status_o
);
  import s3e_pkg::*;

  localparam int unsigned PW   = 2 * DW;
  localparam int unsigned OW   = F + 2;
  localparam int unsigned CNTW = $clog2(DW);
  localparam logic signed [DW-1:0] ONE     = DW'(1) << F;
  localparam logic signed [OW-1:0] ONE_OUT = OW'(1) << F;

  typedef enum logic [9:0] {
    S_IDLE    = 10'b0000000001,
    S_DIVA    = 10'b0000000010,
    S_MUL     = 10'b0000000100,
    S_DIVB_GO = 10'b0000001000,
    S_DIVB    = 10'b0000010000,
    S_SQ      = 10'b0000100000,
    S_SUM     = 10'b0001000000,
    S_SQRT    = 10'b0010000000,
    S_NRM_GO  = 10'b0100000000,
    S_NRM     = 10'b1000000000
  } state_e;

  function automatic logic [DW-1:0] mag_dw(input logic signed [DW-1:0] v);
    mag_dw = v[DW-1] ? DW'(-v) : DW'(v);
  endfunction

  state_e               state_q;
  job_ctrl_t            ctrl_q;
  logic signed [DW-1:0] mul_m_q, x_q, y_q, z_q;
  logic signed [PW-1:0] add_c_q, den_b_q, p_q;
  logic [PW-1:0]        sx_q, sy_q, sz_q, rad_q, res_q, bit_q;
  logic [CNTW-1:0]      cnt_q;
  logic [1:0]           idx_q;
  logic                 done_q;
  logic signed [OW-1:0] vx_q, vy_q, vz_q;
  logic [1:0]           st_q;

  logic                 div_start, div_shift, div_done;
  logic signed [PW-1:0] div_num, div_den;
  logic signed [DW-1:0] div_quo, quo_clamp, comp;
  logic [PW-1:0]        trial, rad_d, res_d;
  logic                 take;

  s3e_div #(.DW(DW), .F(F)) u_div (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(div_start),
    .num_i  (div_num),
    .den_i  (div_den),
    .shift_i(div_shift),
    .done_o (div_done),
    .quo_o  (div_quo)
  );

  // pick the component being normalized
  always_comb begin
    unique case (idx_q)
      2'd0:    comp = x_q;
      2'd1:    comp = y_q;
      2'd2:    comp = z_q;
      default: comp = '0;
    endcase
  end

  // drive the shared divider
  always_comb begin
    pop_o     = (state_q == S_IDLE) && job_valid_i;
    div_start = 1'b0;
    div_num   = num_a_i;
    div_den   = den_a_i;
    div_shift = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        div_start = pop_o && !ctrl_i.imm;
      end
      S_DIVB_GO: begin
        div_start = 1'b1;
        div_num   = add_c_q - p_q;
        div_den   = den_b_q;
        div_shift = 1'b0;
      end
      S_NRM_GO: begin
        div_start = 1'b1;
        div_num   = PW'(comp);
        div_den   = $signed({{DW{1'b0}}, res_q[DW-1:0]});
      end
      default: begin
        div_start = 1'b0;
      end
    endcase
  end

  // clamp a normalized component to the unit range
  always_comb begin
    if (div_quo > ONE)       quo_clamp = ONE;
    else if (div_quo < -ONE) quo_clamp = -ONE;
    else                     quo_clamp = div_quo;
  end

  // one square-root step
  always_comb begin
    trial = res_q + bit_q;
    take  = rad_q >= trial;
    rad_d = take ? rad_q - trial : rad_q;
    res_d = take ? (res_q >> 1) + bit_q : res_q >> 1;
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (state_q)
      S_IDLE: begin
        if (pop_o) begin
          ctrl_q  <= ctrl_i;
          mul_m_q <= mul_m_i;
          add_c_q <= add_c_i;
          den_b_q <= den_b_i;
          vx_q    <= ctrl_i.axis[0] ? ONE_OUT : '0;
          vy_q    <= ctrl_i.axis[1] ? ONE_OUT : '0;
          vz_q    <= ctrl_i.axis[2] ? ONE_OUT : '0;
          st_q    <= ctrl_i.status;
        end
      end
      S_DIVA: begin
        if (div_done) begin
          if (ctrl_q.plane) begin
            y_q <= div_quo;
            x_q <= ctrl_q.plane_yz ? '0 : ONE;
            z_q <= ctrl_q.plane_yz ? ONE : '0;
          end else begin
            x_q <= ONE;
            z_q <= div_quo;
          end
        end
      end
      S_MUL: begin
        p_q <= mul_m_q * z_q;
      end
      S_DIVB: begin
        if (div_done) y_q <= div_quo;
      end
      S_SQ: begin
        sx_q <= PW'(mag_dw(x_q)) * PW'(mag_dw(x_q));
        sy_q <= PW'(mag_dw(y_q)) * PW'(mag_dw(y_q));
        sz_q <= PW'(mag_dw(z_q)) * PW'(mag_dw(z_q));
      end
      S_SUM: begin
        rad_q <= sx_q + sy_q + sz_q;
        res_q <= '0;
        bit_q <= PW'(1) << (PW - 2);
        cnt_q <= '0;
      end
      S_SQRT: begin
        rad_q <= rad_d;
        res_q <= res_d;
        bit_q <= bit_q >> 2;
        cnt_q <= cnt_q + 1'b1;
        idx_q <= 2'd0;
        st_q  <= ST_SOLVED;
        if (res_d == '0) begin
          vx_q <= '0;
          vy_q <= '0;
          vz_q <= '0;
        end
      end
      S_NRM: begin
        if (div_done) begin
          idx_q <= idx_q + 1'b1;
          unique case (idx_q)
            2'd0:    vx_q <= quo_clamp[OW-1:0];
            2'd1:    vy_q <= quo_clamp[OW-1:0];
            default: vz_q <= quo_clamp[OW-1:0];
          endcase
        end
      end
      default: begin
        p_q <= p_q;
      end
    endcase
  end

  // control sequence
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (pop_o) begin
            if (ctrl_i.imm) done_q  <= 1'b1;
            else            state_q <= S_DIVA;
          end
        end
        S_DIVA: begin
          if (div_done) state_q <= ctrl_q.plane ? S_SQ : S_MUL;
        end
        S_MUL:     state_q <= S_DIVB_GO;
        S_DIVB_GO: state_q <= S_DIVB;
        S_DIVB: begin
          if (div_done) state_q <= S_SQ;
        end
        S_SQ:  state_q <= S_SUM;
        S_SUM: state_q <= S_SQRT;
        S_SQRT: begin
          if (cnt_q == CNTW'(DW - 1)) begin
            if (res_d == '0) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_NRM_GO;
            end
          end
        end
        S_NRM_GO: state_q <= S_NRM;
        S_NRM: begin
          if (div_done) begin
            if (idx_q == 2'd2) begin
              done_q  <= 1'b1;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_NRM_GO;
            end
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign done_o   = done_q;
  assign vec_x_o  = vx_q;
  assign vec_y_o  = vy_q;
  assign vec_z_o  = vz_q;
  assign status_o = st_q;

endmodule

// File: src/sym3x3_eigenvector_from_value.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sym3x3_eigenvector_from_value
// Unit eigenvector of a symmetric 3x3 Q8.24 matrix for a given eigenvalue.
//
//   channel | ports                              | handshake
//   --------+------------------------------------+-------------------------
//   in      | a_*_i, lambda_i                    | start_i while !busy_o
//   out     | vec_x_o, vec_y_o, vec_z_o, status_o| done_o, one-cycle strobe
//   config  | tol_wdata_i                        | tol_we_i, no wait
//
// The front takes a word every cycle while busy_o is low and classifies it
// in its registered stages. Aligned, no-solution and no-divider words leave
// the back in the cycle after they are popped. Solved words hold the back
// through the serial divider (one quotient bit a cycle, up to five divides, a
// saturating one ending early) and the serial square root; the back takes no
// word until idle. done_o is a one-cycle strobe; the receiver cannot stall.
// busy_o rises when the word queue plus the front stages fill up.
// Reset clears the control state and sets the tolerance to its default.
// ----------------------------------------------------------------------------
module sym3x3_eigenvector_from_value #(
  parameter int unsigned DATA_WIDTH = s3e_pkg::DATA_WIDTH_DEF,
  parameter int unsigned FRAC_BITS  = s3e_pkg::FRAC_BITS_DEF
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         start_i,
  output logic                         busy_o,
  input  logic signed [DATA_WIDTH-1:0] a_xx_i,
  input  logic signed [DATA_WIDTH-1:0] a_xy_i,
  input  logic signed [DATA_WIDTH-1:0] a_xz_i,
  input  logic signed [DATA_WIDTH-1:0] a_yy_i,
  input  logic signed [DATA_WIDTH-1:0] a_yz_i,
  input  logic signed [DATA_WIDTH-1:0] a_zz_i,
  input  logic signed [DATA_WIDTH-1:0] lambda_i,
  input  logic                         tol_we_i,
  input  logic [FRAC_BITS:0]           tol_wdata_i,
  output logic                         done_o,
  output logic signed [FRAC_BITS+1:0]  vec_x_o,
  output logic signed [FRAC_BITS+1:0]  vec_y_o,
  output logic signed [FRAC_BITS+1:0]  vec_z_o,
  output logic [1:0]                   status_o
);
  import s3e_pkg::*;

  localparam int unsigned PW   = 2 * DATA_WIDTH;
  localparam int unsigned TW   = FRAC_BITS + 1;
  localparam int unsigned CW   = $bits(job_ctrl_t);
  localparam int unsigned JW   = CW + 4 * PW + DATA_WIDTH;
  localparam int unsigned FCW  = $clog2(FIFO_DEPTH + 1);

  logic [TW-1:0]                tol_q;
  logic                         f_valid;
  job_ctrl_t                    f_ctrl, b_ctrl;
  logic signed [PW-1:0]         f_num_a, f_den_a, f_add_c, f_den_b;
  logic signed [PW-1:0]         b_num_a, b_den_a, b_add_c, b_den_b;
  logic signed [DATA_WIDTH-1:0] f_mul_m, b_mul_m;
  logic [1:0]                   inflight;
  logic [JW-1:0]                q_wdata, q_rdata;
  logic                         q_empty, pop;
  logic [FCW-1:0]               q_count;

  // hold the tolerance register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      tol_q <= TW'(TOL_RESET);
    end else if (tol_we_i) begin
      tol_q <= tol_wdata_i;
    end
  end

  s3e_front #(.DW(DATA_WIDTH), .F(FRAC_BITS)) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .valid_i   (start_i && !busy_o),
    .a_xx_i    (a_xx_i),
    .a_xy_i    (a_xy_i),
    .a_xz_i    (a_xz_i),
    .a_yy_i    (a_yy_i),
    .a_yz_i    (a_yz_i),
    .a_zz_i    (a_zz_i),
    .lambda_i  (lambda_i),
    .tol_i     (tol_q),
    .valid_o   (f_valid),
    .ctrl_o    (f_ctrl),
    .num_a_o   (f_num_a),
    .den_a_o   (f_den_a),
    .mul_m_o   (f_mul_m),
    .add_c_o   (f_add_c),
    .den_b_o   (f_den_b),
    .inflight_o(inflight)
  );

  assign q_wdata = {f_ctrl, f_num_a, f_den_a, f_mul_m, f_add_c, f_den_b};

  s3e_fifo #(.WIDTH(JW), .DEPTH(FIFO_DEPTH)) u_fifo (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .push_i (f_valid),
    .wdata_i(q_wdata),
    .pop_i  (pop),
    .rdata_o(q_rdata),
    .empty_o(q_empty),
    .count_o(q_count)
  );

  assign {b_ctrl, b_num_a, b_den_a, b_mul_m, b_add_c, b_den_b} = q_rdata;

  // stall input when the queue could overflow
  assign busy_o = ((FCW + 1)'(q_count) + (FCW + 1)'(inflight))
                  >= (FCW + 1)'(FIFO_DEPTH);

  s3e_back #(.DW(DATA_WIDTH), .F(FRAC_BITS)) u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .job_valid_i(!q_empty),
    .pop_o      (pop),
    .ctrl_i     (b_ctrl),
    .num_a_i    (b_num_a),
    .den_a_i    (b_den_a),
    .mul_m_i    (b_mul_m),
    .add_c_i    (b_add_c),
    .den_b_i    (b_den_b),
    .done_o     (done_o),
    .vec_x_o    (vec_x_o),
    .vec_y_o    (vec_y_o),
    .vec_z_o    (vec_z_o),
    .status_o   (status_o)
  );

endmodule

// File: src/s3e_chk.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s3e_chk
// Port-level checks on result words of the eigenvector block.
// ----------------------------------------------------------------------------
module s3e_chk #(
  parameter int unsigned OW = 26
) (
  input logic                 clk_i,
  input logic                 rst_ni,
  input logic                 done_o,
  input logic signed [OW-1:0] vec_x_o,
  input logic signed [OW-1:0] vec_y_o,
  input logic signed [OW-1:0] vec_z_o,
  input logic [1:0]           status_o
);
  import s3e_pkg::*;

  localparam logic signed [OW-1:0] ONE = OW'(1) << (OW - 2);

  // aligned words carry exactly one unit axis
  a_aligned_axis: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_ALIGNED) |->
      ((vec_x_o == ONE && vec_y_o == '0 && vec_z_o == '0) ||
       (vec_x_o == '0 && vec_y_o == ONE && vec_z_o == '0) ||
       (vec_x_o == '0 && vec_y_o == '0 && vec_z_o == ONE)))
    else $error("aligned word is not a unit axis");

  // failure words carry a zero vector
  a_fail_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && (status_o == ST_NOSOL || status_o == ST_NODIV)) |->
      (vec_x_o == '0 && vec_y_o == '0 && vec_z_o == '0))
    else $error("failure word has a nonzero vector");

  // solved components stay within the unit range
  a_solved_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && status_o == ST_SOLVED) |->
      (vec_x_o <= ONE && vec_x_o >= -ONE && vec_y_o <= ONE && vec_y_o >= -ONE &&
       vec_z_o <= ONE && vec_z_o >= -ONE))
    else $error("solved component out of range");

  // no word leaves in the cycle right after reset
  a_quiet_reset: assert property (@(posedge clk_i)
    $rose(rst_ni) |-> !done_o)
    else $error("result strobe out of reset");

endmodule

bind sym3x3_eigenvector_from_value s3e_chk #(.OW(FRAC_BITS + 2)) u_s3e_chk (.*);
